// ----- rtl/idq_pkg.sv -----
// idq_pkg: operation and status codes, error word and the command/status
// structs shared by the deque controller, datapath and checker
// no dependencies
package idq_pkg;

  // field widths fixed by the interface
  localparam int KIND_W  = 3;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_IDX   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WRITE_IDX  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // word returned on any error
  localparam logic signed [WORD_W-1:0] ERR_WORD = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input word into the operand registers
    logic exec;      // run the operation, update pointers, load the result
    logic load_rd;   // replace the result word with the ram read data
  } idq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read; // the pending operation fetches an entry
  } idq_stat_t;

endpackage

// ----- rtl/idq_ram.sv -----
// idq_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/idq_ctrl.sv -----
// idq_ctrl: sequencing state machine of the deque, drives the handshakes
// depends on idq_pkg
module idq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output idq_pkg::idq_cmd_t    cmd,
  input  idq_pkg::idq_stat_t   stat
);
  import idq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MEM  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // a new word is taken when idle or as the held result leaves
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_ready);
  assign out_valid = (state_r == S_RESP);
  assign accept    = in_valid && in_ready;

  // commands
  always_comb begin
    cmd.capture = accept;
    cmd.exec    = (state_r == S_EXEC);
    cmd.load_rd = (state_r == S_MEM);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = stat.need_read ? S_MEM : S_RESP;
      end
      S_MEM: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end else if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/idq_datapath.sv -----
// idq_datapath: operand and result registers, ring pointers and entry ram
// depends on idq_pkg and idq_ram
module idq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  idq_pkg::idq_cmd_t                   cmd,
  output idq_pkg::idq_stat_t                  stat,
  input  logic [idq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [idq_pkg::WORD_W-1:0]   in_value,
  input  logic [idq_pkg::POS_W-1:0]           in_position,
  output logic signed [idq_pkg::WORD_W-1:0]   out_word,
  output logic [idq_pkg::STAT_W-1:0]          out_status,
  output logic [$clog2(DEPTH+1)-1:0]          out_occupancy
);
  import idq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (POS_W > CW) ? POS_W : CW;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // operand registers
  logic [KIND_W-1:0]        kind_r;
  logic signed [WORD_W-1:0] value_r;
  logic [POS_W-1:0]         pos_r;

  // queue state
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // result registers
  logic signed [WORD_W-1:0] word_r;
  logic [STAT_W-1:0]        status_r;
  logic [CW-1:0]            occ_r;

  // operation decode
  logic                     is_full, is_empty, in_range;
  logic                     op_we, op_re, use_front, use_dec;
  logic [AW-1:0]            offset, front_inc, front_dec, ring_addr, addr;
  logic [AW:0]              ring_sum;
  logic signed [WORD_W-1:0] word_c;
  logic [STAT_W-1:0]        status_c;
  logic [WORD_W-1:0]        rdata;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  // checks and neighbor pointers
  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);
  assign in_range  = (PW'(pos_r) < PW'(count_r));
  assign front_inc = (front_r == LAST_A) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LAST_A : front_r - 1'b1;

  // decode the operation
  always_comb begin
    op_we     = 1'b0;
    op_re     = 1'b0;
    use_front = 1'b0;
    use_dec   = 1'b0;
    offset    = '0;
    front_nxt = front_r;
    count_nxt = count_r;
    word_c    = '0;
    status_c  = ST_OK;
    case (kind_r)
      KIND_PUSH_BACK: begin
        if (is_full) begin
          word_c   = ERR_WORD;
          status_c = ST_FULL;
        end else begin
          op_we     = 1'b1;
          offset    = AW'(count_r);
          count_nxt = count_r + 1'b1;
          word_c    = value_r;
        end
      end
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          word_c   = ERR_WORD;
          status_c = ST_FULL;
        end else begin
          op_we     = 1'b1;
          use_dec   = 1'b1;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          word_c    = value_r;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          word_c   = ERR_WORD;
          status_c = ST_EMPTY;
        end else begin
          op_re     = 1'b1;
          offset    = AW'(count_r - 1'b1);
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          word_c   = ERR_WORD;
          status_c = ST_EMPTY;
        end else begin
          op_re     = 1'b1;
          use_front = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_READ_IDX: begin
        if (!in_range) begin
          word_c   = ERR_WORD;
          status_c = ST_RANGE;
        end else begin
          op_re  = 1'b1;
          offset = AW'(pos_r);
        end
      end
      KIND_WRITE_IDX: begin
        if (!in_range) begin
          word_c   = ERR_WORD;
          status_c = ST_RANGE;
        end else begin
          op_we  = 1'b1;
          offset = AW'(pos_r);
          word_c = value_r;
        end
      end
      default: begin
        word_c = '0;
      end
    endcase
  end

  // ring position: front plus offset, wrapped once
  assign ring_sum  = {1'b0, front_r} + {1'b0, offset};
  assign ring_addr = (ring_sum >= DEPTH_A) ? AW'(ring_sum - DEPTH_A) : ring_sum[AW-1:0];
  assign addr      = use_dec ? front_dec : (use_front ? front_r : ring_addr);

  assign stat.need_read = op_re;

  // entry storage
  idq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && op_we),
    .waddr (addr),
    .wdata (value_r),
    .re    (cmd.exec && op_re),
    .raddr (addr),
    .rdata (rdata)
  );

  // pointer and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      word_r   <= word_c;
      status_r <= status_c;
      occ_r    <= count_nxt;
    end else if (cmd.load_rd) begin
      word_r   <= rdata;
    end
  end

  assign out_word      = word_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

endmodule

// ----- rtl/indexed_double_ended_queue_unit.sv -----
// indexed_double_ended_queue_unit: top level of the indexed deque
// depends on idq_pkg, idq_ctrl and idq_datapath
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation word: in_kind,
//   in_value, in_position. Result channel (out_valid/out_ready) returns
//   one word per operation: out_word, out_status, out_occupancy.
//   Entries sit in a ring of DEPTH words in a ram with one write port and
//   one registered read port.
// Timing: after acceptance a push, write, error or unused code passes
//   through the execute state to the response state, where out_valid is
//   high; pops and reads add a memory state for the registered ram read.
// Flow: a new operation is not taken until the last result leaves; the next
//   word is taken in the same cycle the held result is taken, so no idle
//   state lies between operations once the receiver is ready.
// Reset: rst_n clears the state machine, the front pointer and the count;
//   the queue comes up empty with no clearing pass.
// Stall: while out_ready is low the result holds on the outputs and
//   in_ready stays low.
module indexed_double_ended_queue_unit #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [idq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [idq_pkg::WORD_W-1:0]   in_value,
  input  logic [idq_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [idq_pkg::WORD_W-1:0]   out_word,
  output logic [idq_pkg::STAT_W-1:0]          out_status,
  output logic [$clog2(DEPTH+1)-1:0]          out_occupancy
);
  import idq_pkg::*;

  idq_cmd_t  cmd;
  idq_stat_t stat;

  // sequencing
  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and result
  idq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_word      (out_word),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule

// ----- rtl/idq_checker.sv -----
// idq_checker: port-level assertions for the indexed deque, bound to the top
// depends on idq_pkg and indexed_double_ended_queue_unit
module idq_checker #(
  parameter int DEPTH = 64
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [idq_pkg::WORD_W-1:0]   out_word,
  input logic [idq_pkg::STAT_W-1:0]          out_status,
  input logic [$clog2(DEPTH+1)-1:0]          out_occupancy
);
  import idq_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_status))
    else $error("result changed while stalled");

  // count never passes the ring size
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("occupancy above depth");

  // every error returns the error word
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_word == ERR_WORD)
    else $error("error status without error word");

  // empty and full flags agree with the count
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != ST_EMPTY || out_occupancy == '0) &&
                  (out_status != ST_FULL ||
                   out_occupancy == ($clog2(DEPTH+1))'(DEPTH)))
    else $error("status flag disagrees with occupancy");

endmodule

bind indexed_double_ended_queue_unit idq_checker #(.DEPTH(DEPTH)) u_idq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_word      (out_word),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);
